>>> rtl/playfair_digram_cipher_top_macros.svh
// Assertion macros used by the Playfair cipher core.
`ifndef PLAYFAIR_DIGRAM_CIPHER_TOP_MACROS_SVH
`define PLAYFAIR_DIGRAM_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pf_pkg.sv
// Package with the types, codes and helper functions of the Playfair cipher.
package pf_pkg;

  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_KEY   = 3'd1;
  localparam logic [2:0] ACT_CLOSE = 3'd2;
  localparam logic [2:0] ACT_TEXT  = 3'd3;
  localparam logic [2:0] ACT_END   = 3'd4;

  localparam logic [4:0] IDX_I       = 5'd8;
  localparam logic [4:0] IDX_J       = 5'd9;
  localparam logic [4:0] IDX_X       = 5'd23;
  localparam logic [4:0] LAST_LETTER = 5'd25;
  localparam logic [4:0] CELLS       = 5'd25;
  localparam logic [2:0] SIDE_LAST   = 3'd4;
  localparam logic [6:0] ASCII_A     = 7'd65;

  localparam int unsigned ALPHA_DEPTH  = 26;
  localparam int unsigned SQUARE_DEPTH = 25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_POS,
    ST_OUT_A,
    ST_OUT_B
  } pf_state_e;

  typedef struct packed {
    logic       valid;
    logic [4:0] idx;
  } pf_fold_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] letter;
    logic       last;
  } pf_out_t;

  function automatic pf_fold_t fold_letter(input logic [7:0] c);
    logic [7:0] u;
    pf_fold_t   r;
    u = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
    r.valid = (u >= 8'h41) && (u <= 8'h5A);
    r.idx = 5'(u - 8'h41);
    if (r.idx == IDX_J) begin
      r.idx = IDX_I;
    end
    return r;
  endfunction

  function automatic logic [2:0] step_coord(input logic [2:0] v, input logic dec);
    logic [2:0] r;
    if (dec) begin
      r = (v == 3'd0) ? SIDE_LAST : (v - 3'd1);
    end else begin
      r = (v == SIDE_LAST) ? 3'd0 : (v + 3'd1);
    end
    return r;
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

>>> rtl/pf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pf_core.sv
// Key square builder and digram engine around the square and position memories.
`include "playfair_digram_cipher_top_macros.svh"

module pf_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mode_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      action_i,
  input  logic [7:0]      char_i,
  output pf_pkg::pf_out_t out_o,
  input  logic            out_ready_i
);

  pf_pkg::pf_state_e state_q, state_d;

  logic [25:0] used_q, used_d;
  logic [4:0]  fill_q, fill_d;
  logic [2:0]  frow_q, frow_d;
  logic [2:0]  fcol_q, fcol_d;
  logic        key_ready_q, key_ready_d;
  logic        held_valid_q, held_valid_d;
  logic [2:0]  held_row_q, held_row_d;
  logic [2:0]  held_col_q, held_col_d;
  logic        prev_valid_q, prev_valid_d;
  logic [4:0]  prev_letter_q, prev_letter_d;
  logic        pend_valid_q, pend_valid_d;
  logic [4:0]  pend_letter_q, pend_letter_d;
  logic [4:0]  k_q, k_d;
  logic [4:0]  celly_q, celly_d;

  logic             accept;
  pf_pkg::pf_fold_t fold;
  logic             text_go, end_go, close_go, close_done, ins_x;
  logic [4:0]       first_letter;
  logic             app_req, app_do;
  logic [4:0]       app_idx;
  logic             emit_a, emit_b;

  logic       pos_re, sq_re;
  logic [4:0] pos_raddr, sq_raddr;
  logic [5:0] pos_rdata;
  logic [4:0] sq_rdata;

  logic [2:0] rb, cb, rx, cx, ry, cy;
  logic [4:0] cell_x, cell_y;

  assign accept     = in_valid_i && (state_q == pf_pkg::ST_IDLE);
  assign fold       = pf_pkg::fold_letter(char_i);
  assign text_go    = accept && (action_i == pf_pkg::ACT_TEXT) && key_ready_q && fold.valid;
  assign end_go     = accept && (action_i == pf_pkg::ACT_END) && key_ready_q && held_valid_q;
  assign close_go   = accept && (action_i == pf_pkg::ACT_CLOSE) && !key_ready_q;
  assign close_done = (state_q == pf_pkg::ST_CLOSE) && (k_q == pf_pkg::LAST_LETTER);
  assign ins_x      = !mode_i && prev_valid_q && (prev_letter_q == fold.idx);
  assign first_letter = (end_go || ins_x) ? pf_pkg::IDX_X : fold.idx;
  assign emit_a     = (state_q == pf_pkg::ST_OUT_A) && out_ready_i;
  assign emit_b     = (state_q == pf_pkg::ST_OUT_B) && out_ready_i;

  always_comb begin
    app_req = 1'b0;
    app_idx = k_q;
    if (state_q == pf_pkg::ST_CLOSE) begin
      app_req = (k_q != pf_pkg::IDX_J);
    end else if (accept && (action_i == pf_pkg::ACT_KEY) && !key_ready_q && fold.valid) begin
      app_req = 1'b1;
      app_idx = fold.idx;
    end
  end

  assign app_do = app_req && !used_q[app_idx] && (fill_q < pf_pkg::CELLS);

  // Digram rule: same row shifts along the row, same column along the column,
  // otherwise the two letters trade columns.
  assign rb = pos_rdata[5:3];
  assign cb = pos_rdata[2:0];

  always_comb begin
    if (held_row_q == rb) begin
      rx = held_row_q;
      cx = pf_pkg::step_coord(held_col_q, mode_i);
      ry = rb;
      cy = pf_pkg::step_coord(cb, mode_i);
    end else if (held_col_q == cb) begin
      rx = pf_pkg::step_coord(held_row_q, mode_i);
      cx = held_col_q;
      ry = pf_pkg::step_coord(rb, mode_i);
      cy = cb;
    end else begin
      rx = held_row_q;
      cx = cb;
      ry = rb;
      cy = held_col_q;
    end
  end

  assign cell_x = pf_pkg::cell_addr(rx, cx);
  assign cell_y = pf_pkg::cell_addr(ry, cy);

  pf_ram #(
    .WIDTH(5),
    .DEPTH(pf_pkg::SQUARE_DEPTH)
  ) u_square (
    .clk_i  (clk_i),
    .we_i   (app_do),
    .waddr_i(fill_q),
    .wdata_i(app_idx),
    .re_i   (sq_re),
    .raddr_i(sq_raddr),
    .rdata_o(sq_rdata)
  );

  pf_ram #(
    .WIDTH(6),
    .DEPTH(pf_pkg::ALPHA_DEPTH)
  ) u_pos (
    .clk_i  (clk_i),
    .we_i   (app_do),
    .waddr_i(app_idx),
    .wdata_i({frow_q, fcol_q}),
    .re_i   (pos_re),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pf_pkg::ST_IDLE: begin
        if (close_go) begin
          state_d = pf_pkg::ST_CLOSE;
        end else if (text_go || end_go) begin
          state_d = pf_pkg::ST_POS;
        end
      end
      pf_pkg::ST_CLOSE: begin
        if (close_done) begin
          state_d = pf_pkg::ST_IDLE;
        end
      end
      pf_pkg::ST_POS: begin
        if (held_valid_q) begin
          state_d = pf_pkg::ST_OUT_A;
        end else if (!pend_valid_q) begin
          state_d = pf_pkg::ST_IDLE;
        end
      end
      pf_pkg::ST_OUT_A: begin
        if (out_ready_i) begin
          state_d = pf_pkg::ST_OUT_B;
        end
      end
      pf_pkg::ST_OUT_B: begin
        if (out_ready_i) begin
          state_d = pend_valid_q ? pf_pkg::ST_POS : pf_pkg::ST_IDLE;
        end
      end
      default: state_d = pf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    pos_re     = 1'b0;
    pos_raddr  = pend_letter_q;
    sq_re      = 1'b0;
    sq_raddr   = celly_q;
    out_o      = '{valid: 1'b0, letter: pf_pkg::ASCII_A + {2'b00, sq_rdata}, last: 1'b0};
    unique case (state_q)
      pf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        pos_re     = text_go || end_go;
        pos_raddr  = first_letter;
      end
      pf_pkg::ST_CLOSE: begin
        pos_re = 1'b0;
      end
      pf_pkg::ST_POS: begin
        pos_re   = !held_valid_q && pend_valid_q;
        sq_re    = held_valid_q;
        sq_raddr = cell_x;
      end
      pf_pkg::ST_OUT_A: begin
        out_o.valid = 1'b1;
        sq_re       = out_ready_i;
      end
      pf_pkg::ST_OUT_B: begin
        out_o.valid = 1'b1;
        out_o.last  = 1'b1;
        pos_re      = out_ready_i && pend_valid_q;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    used_d        = used_q;
    fill_d        = fill_q;
    frow_d        = frow_q;
    fcol_d        = fcol_q;
    key_ready_d   = key_ready_q;
    held_valid_d  = held_valid_q;
    held_row_d    = held_row_q;
    held_col_d    = held_col_q;
    prev_valid_d  = prev_valid_q;
    prev_letter_d = prev_letter_q;
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    k_d           = k_q;
    celly_d       = celly_q;

    if (app_do) begin
      used_d[app_idx] = 1'b1;
      fill_d = fill_q + 5'd1;
      if (fcol_q == pf_pkg::SIDE_LAST) begin
        fcol_d = 3'd0;
        frow_d = frow_q + 3'd1;
      end else begin
        fcol_d = fcol_q + 3'd1;
      end
    end

    if (accept && (action_i == pf_pkg::ACT_START)) begin
      used_d       = '0;
      fill_d       = '0;
      frow_d       = '0;
      fcol_d       = '0;
      key_ready_d  = 1'b0;
      held_valid_d = 1'b0;
      prev_valid_d = 1'b0;
    end

    if (close_go) begin
      k_d = '0;
    end
    if (state_q == pf_pkg::ST_CLOSE) begin
      k_d = k_q + 5'd1;
      if (close_done) begin
        key_ready_d = 1'b1;
      end
    end

    if (text_go) begin
      pend_valid_d  = ins_x;
      pend_letter_d = fold.idx;
      prev_letter_d = fold.idx;
      prev_valid_d  = 1'b1;
    end
    if (accept && (action_i == pf_pkg::ACT_END) && key_ready_q) begin
      prev_valid_d = 1'b0;
      pend_valid_d = 1'b0;
    end

    if (state_q == pf_pkg::ST_POS) begin
      if (held_valid_q) begin
        held_valid_d = 1'b0;
        celly_d      = cell_y;
      end else begin
        held_valid_d = 1'b1;
        held_row_d   = rb;
        held_col_d   = cb;
        pend_valid_d = 1'b0;
      end
    end
    if (emit_b) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pf_pkg::ST_IDLE;
      used_q       <= '0;
      fill_q       <= '0;
      frow_q       <= '0;
      fcol_q       <= '0;
      key_ready_q  <= 1'b0;
      held_valid_q <= 1'b0;
      prev_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      k_q          <= '0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      fill_q       <= fill_d;
      frow_q       <= frow_d;
      fcol_q       <= fcol_d;
      key_ready_q  <= key_ready_d;
      held_valid_q <= held_valid_d;
      prev_valid_q <= prev_valid_d;
      pend_valid_q <= pend_valid_d;
      k_q          <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_row_q    <= held_row_d;
    held_col_q    <= held_col_d;
    prev_letter_q <= prev_letter_d;
    pend_letter_q <= pend_letter_d;
    celly_q       <= celly_d;
  end

  `PF_ASSERT_IMP(a_fill_max, 1'b1, fill_q <= pf_pkg::CELLS, "Fill count beyond the square size.")
  `PF_ASSERT_IMP(a_key_full, key_ready_q, fill_q == pf_pkg::CELLS, "Key closed with square not full.")
  `PF_ASSERT_IMP(a_pend_idle, state_q == pf_pkg::ST_IDLE, !pend_valid_q, "Letter left pending in idle.")
  `PF_ASSERT_NXT(a_pair_order, emit_a, state_q == pf_pkg::ST_OUT_B, "First letter without second.")

endmodule

>>> rtl/playfair_digram_cipher_top.sv
// Top level of the Playfair digram cipher with mode register and output register.
//
// The slave stream carries one item per handshake: tuser holds the action
// (start key, key character, close key, text character, end text) and tdata
// the raw ASCII character. The master stream returns cipher or plain letters,
// two per digram, with tlast marking the second letter of each digram.
// The mode register (0 encrypt, 1 decrypt) is written through cfg_we_i.
// A key character is taken without leaving the idle state. Closing the key
// runs through the alphabet, one letter per cycle into the square memory. A
// text character that only waits for its mate needs one position memory read;
// one that completes a digram also needs a square memory read for each output
// letter, and an inserted X needs a position memory read of its own. End text
// pads an odd letter with X and emits the digram. The first result of a
// digram passes the square memory read and the output register before it
// appears on the master side. When the receiver
// stalls, the result waits in the output register and the engine holds; no new
// item is taken until both letters of the digram have entered that register.
// Reset clears the key, the pairing state and the mode; the square and
// position memories are not cleared and are rebuilt by the next key.
module playfair_digram_cipher_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] character
  input  logic [2:0] s_axis_tuser,   // [2:0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] letter, [7] zero
  output logic       m_axis_tlast
);

  logic            mode_q;
  pf_pkg::pf_out_t core_out;
  logic            core_out_ready;
  logic            out_valid_q;
  logic [6:0]      out_letter_q;
  logic            out_last_q;

  assign core_out_ready = !out_valid_q || m_axis_tready;

  pf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .char_i     (s_axis_tdata),
    .out_o      (core_out),
    .out_ready_i(core_out_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (core_out.valid && core_out_ready) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_out.valid && core_out_ready) begin
      out_letter_q <= core_out.letter;
      out_last_q   <= core_out.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_letter_q};
  assign m_axis_tlast  = out_last_q;

endmodule

>>> test/tb_playfair_digram_cipher_top.sv
// Self-checking stream testbench for the Playfair digram cipher top level.
`timescale 1ns / 100ps

module tb_playfair_digram_cipher_top;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  localparam int SIDE          = 5;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int ITEM_TARGET   = 730;
  localparam int SHOWN_FAILS   = 10;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } pf_result_t;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] ch;
    logic       typed;
    logic [1:0] n_typed;
    logic [6:0] l0;
    logic [6:0] l1;
    logic       wr;
    logic       wmode;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  logic       pf_mode;
  logic [4:0] pf_square [pf_pkg::SQUARE_DEPTH];
  logic [2:0] pf_row [pf_pkg::ALPHA_DEPTH];
  logic [2:0] pf_col [pf_pkg::ALPHA_DEPTH];
  bit         pf_used [pf_pkg::ALPHA_DEPTH];
  int         pf_fill;
  bit         pf_key_closed;
  bit         pf_held_valid;
  logic [4:0] pf_held;
  bit         pf_prev_valid;
  logic [4:0] pf_prev;

  pf_result_t expected_q [$];
  pf_result_t exp_res;
  bit         quiet_run;
  int         fails;
  int         items_sent;
  int         letters_checked;
  int         sessions;
  int         mode_writes;
  int         idle_cycles;

  stim_row_t directed_tab [26] = '{
    '{pf_pkg::ACT_TEXT,  "A",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_END,   8'h00, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{ACT_SPARE_FIRST,   "A",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{ACT_SPARE_LAST,    8'hFF, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_CLOSE, 8'h00, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_KEY,   "Q",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_CLOSE, 8'hFF, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  "A",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  "B",   1'b1, 2'd2, 7'h42, 7'h43, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  "a",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  "F",   1'b1, 2'd2, 7'h46, 7'h4C, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  " ",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  "Z",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  8'h00, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  "z",   1'b0, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_END,   8'h00, 1'b0, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_START, 8'h00, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_KEY,   "p",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_KEY,   " ",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_KEY,   "j",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_KEY,   8'hFF, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_CLOSE, 8'h00, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  "J",   1'b0, 2'd0, 7'h00, 7'h00, 1'b1, 1'b1},
    '{pf_pkg::ACT_TEXT,  "i",   1'b0, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_TEXT,  "Q",   1'b0, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0},
    '{pf_pkg::ACT_END,   8'hFF, 1'b0, 2'd0, 7'h00, 7'h00, 1'b0, 1'b0}
  };

  playfair_digram_cipher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic int fold_char(input logic [7:0] c);
    logic [7:0] u;
    int         idx;
    u = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
    if ((u < 8'h41) || (u > 8'h5A)) return -1;
    idx = int'(u) - 8'h41;
    if (idx == pf_pkg::IDX_J) idx = pf_pkg::IDX_I;
    return idx;
  endfunction

  function automatic logic [6:0] cell_char(input int r, input int c);
    return pf_pkg::ASCII_A + 7'(pf_square[(r % SIDE) * SIDE + (c % SIDE)]);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(0, 25));
  endfunction

  task automatic add_result(ref pf_result_t res_q [$], input logic [6:0] letter,
                            input logic last);
    pf_result_t r;
    r.letter = letter;
    r.last   = last;
    res_q.insert(res_q.size(), r);
  endtask

  task automatic model_reset();
    pf_mode       = 1'b0;
    pf_fill       = 0;
    pf_key_closed = 1'b0;
    pf_held_valid = 1'b0;
    pf_held       = '0;
    pf_prev_valid = 1'b0;
    pf_prev       = '0;
    foreach (pf_used[k]) pf_used[k] = 1'b0;
  endtask

  task automatic model_reset_key();
    logic keep_mode;
    keep_mode = pf_mode;
    model_reset();
    pf_mode = keep_mode;
  endtask

  task automatic add_letter(input int idx);
    if (pf_used[idx] || (pf_fill >= pf_pkg::SQUARE_DEPTH)) return;
    pf_used[idx]       = 1'b1;
    pf_square[pf_fill] = 5'(idx);
    pf_row[idx]        = 3'(pf_fill / SIDE);
    pf_col[idx]        = 3'(pf_fill % SIDE);
    pf_fill++;
  endtask

  task automatic feed_letter(input int idx, ref pf_result_t res_q [$]);
    int ra, ca, rb, cb, st;
    if (!pf_held_valid) begin
      pf_held       = 5'(idx);
      pf_held_valid = 1'b1;
      return;
    end
    pf_held_valid = 1'b0;
    ra = pf_row[pf_held];
    ca = pf_col[pf_held];
    rb = pf_row[idx];
    cb = pf_col[idx];
    st = pf_mode ? SIDE - 1 : 1;
    if (ra == rb) begin
      add_result(res_q, cell_char(ra, ca + st), 1'b0);
      add_result(res_q, cell_char(rb, cb + st), 1'b1);
    end else if (ca == cb) begin
      add_result(res_q, cell_char(ra + st, ca), 1'b0);
      add_result(res_q, cell_char(rb + st, cb), 1'b1);
    end else begin
      add_result(res_q, cell_char(ra, cb), 1'b0);
      add_result(res_q, cell_char(rb, ca), 1'b1);
    end
  endtask

  task automatic cipher_predict(input logic [2:0] act, input logic [7:0] ch,
                                ref pf_result_t res_q [$]);
    int idx;
    idx = fold_char(ch);
    case (act)
      pf_pkg::ACT_START: begin
        model_reset_key();
      end
      pf_pkg::ACT_KEY: begin
        if (!pf_key_closed && (idx >= 0)) add_letter(idx);
      end
      pf_pkg::ACT_CLOSE: begin
        if (!pf_key_closed) begin
          for (int k = 0; k < pf_pkg::ALPHA_DEPTH; k++) begin
            if (k != pf_pkg::IDX_J) add_letter(k);
          end
          pf_key_closed = 1'b1;
        end
      end
      pf_pkg::ACT_TEXT: begin
        if (pf_key_closed && (idx >= 0)) begin
          if (!pf_mode && pf_prev_valid && (pf_prev == idx)) begin
            feed_letter(pf_pkg::IDX_X, res_q);
          end
          feed_letter(idx, res_q);
          pf_prev       = 5'(idx);
          pf_prev_valid = 1'b1;
        end
      end
      pf_pkg::ACT_END: begin
        if (pf_key_closed) begin
          if (pf_held_valid) feed_letter(pf_pkg::IDX_X, res_q);
          pf_held_valid = 1'b0;
          pf_prev_valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic log_failure(input string msg);
    fails++;
    if (fails <= SHOWN_FAILS) $display("ERROR: %s", msg);
  endtask

  task automatic send_item(input logic [2:0] act, input logic [7:0] ch,
                           input bit typed = 1'b0, input int n_typed = 0,
                           input logic [6:0] l0 = '0, input logic [6:0] l1 = '0);
    int         gap;
    pf_result_t res_q [$];
    gap = quiet_run ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    cipher_predict(act, ch, res_q);
    if (typed) begin
      res_q.delete();
      if (n_typed > 0) add_result(res_q, l0, 1'b0);
      if (n_typed > 1) add_result(res_q, l1, 1'b1);
    end
    foreach (res_q[k]) add_result(expected_q, res_q[k].letter, res_q[k].last);
    if (act <= pf_pkg::ACT_END) items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic write_mode(input logic m);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pf_mode = m;
    mode_writes++;
  endtask

  task automatic run_session();
    int         n_key, n_text, pick, j;
    logic [7:0] perm [26];
    logic [7:0] ch, tmp, last_ch;
    quiet_run = ($urandom_range(0, 3) == 0);
    if (sessions == 0) write_mode(1'b0);
    else if ($urandom_range(0, 2) == 0) write_mode(1'($urandom_range(0, 1)));
    send_item(pf_pkg::ACT_START, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < 26; k++) begin
        perm[k] = (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(k);
      end
      for (int k = 25; k > 0; k--) begin
        j       = $urandom_range(0, k);
        tmp     = perm[k];
        perm[k] = perm[j];
        perm[j] = tmp;
      end
      foreach (perm[k]) send_item(pf_pkg::ACT_KEY, perm[k]);
      repeat (3) send_item(pf_pkg::ACT_KEY, rand_letter());
    end else begin
      n_key = $urandom_range(0, 10);
      repeat (n_key) begin
        ch = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : rand_letter();
        send_item(pf_pkg::ACT_KEY, ch);
      end
    end
    if ($urandom_range(0, 5) == 0) send_item(pf_pkg::ACT_TEXT, rand_letter());
    send_item(pf_pkg::ACT_CLOSE, 8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 11);
    if (pick == 0) send_item(pf_pkg::ACT_KEY, rand_letter());
    else if (pick == 1) send_item(pf_pkg::ACT_CLOSE, 8'($urandom_range(0, 255)));
    n_text  = $urandom_range(1, 20);
    last_ch = rand_letter();
    repeat (n_text) begin
      pick = $urandom_range(0, 19);
      if (pick < 5) ch = last_ch ^ (8'($urandom_range(0, 1)) << 5);
      else if (pick < 7) ch = 8'($urandom_range(0, 255));
      else ch = rand_letter();
      send_item(pf_pkg::ACT_TEXT, ch);
      if (fold_char(ch) >= 0) last_ch = ch;
      if ($urandom_range(0, 24) == 0) write_mode(~pf_mode);
      if ($urandom_range(0, 29) == 0) begin
        send_item(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
                  8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 4) == 0) drain_results();
    if ($urandom_range(0, 7) != 0) send_item(pf_pkg::ACT_END, 8'($urandom_range(0, 255)));
    sessions++;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet_run && ($urandom_range(0, 5) != 0)) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      letters_checked++;
      if (expected_q.size() == 0) begin
        log_failure($sformatf("unexpected letter %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        exp_res = expected_q.pop_front();
        if ((m_axis_tdata != {1'b0, exp_res.letter}) || (m_axis_tlast != exp_res.last)) begin
          log_failure($sformatf("expected letter %h last %b, got letter %h last %b",
                                {1'b0, exp_res.letter}, exp_res.last,
                                m_axis_tdata, m_axis_tlast));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    quiet_run     = 1'b0;
    idle_cycles   = 0;
    model_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(directed_tab); i++) begin
      if (directed_tab[i].wr) write_mode(directed_tab[i].wmode);
      send_item(directed_tab[i].act, directed_tab[i].ch, directed_tab[i].typed,
                int'(directed_tab[i].n_typed), directed_tab[i].l0, directed_tab[i].l1);
    end
    while (items_sent < ITEM_TARGET) run_session();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      log_failure($sformatf("%0d expected letters never arrived", expected_q.size()));
    end
    $display("Sent %0d items over %0d random key sessions with %0d mode writes.",
             items_sent, sessions, mode_writes);
    $display("Checked %0d output letters; %0d mismatches.", letters_checked, fails);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
